FILE: rtl/u16u8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 encoder.
// Used by the front, the run queue, the byte sender and the top level.
package u16u8_pkg;

    localparam int MAX_BYTES = 6;
    localparam int IDX_W     = $clog2(MAX_BYTES + 1);
    localparam int Q_DEPTH   = 2;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int Q_CW      = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    localparam logic [5:0]  SURR_HI_TAG = 6'b110110;
    localparam logic [5:0]  SURR_LO_TAG = 6'b110111;
    localparam logic [10:0] PLANE_ADD   = 11'h040;

    // One run of UTF-8 bytes caused by one code unit, in output order.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [IDX_W-1:0]          count;
        logic                      term;
    } run_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

endpackage

FILE: rtl/u16u8_front.sv
// Front end: accepts code units, tracks the held high surrogate and
// builds the full byte run for each word. Depends on u16u8_pkg.
module u16u8_front
    import u16u8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] code_unit,
    input  q_status_t   q_status,
    output logic        push,
    output run_t        run
);

    logic       held_valid_reg;
    logic       held_valid_next;
    logic [9:0] held_bits_reg;
    logic [9:0] held_bits_next;

    logic        accept;
    logic        is_high;
    logic        is_low;
    logic [10:0] plane;
    logic [2:0][7:0] m_bytes;
    logic [IDX_W-1:0] m_count;
    logic        m_term;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign is_high  = (code_unit[15:10] == SURR_HI_TAG);
    assign is_low   = (code_unit[15:10] == SURR_LO_TAG);
    // Upper bits of the code point: held bits plus one plane.
    assign plane    = {1'b0, held_bits_reg} + PLANE_ADD;

    always_comb
    begin
        m_bytes = '0;
        m_count = '0;
        m_term  = 1'b0;
        priority if (code_unit == 16'h0000)
        begin
            m_count = IDX_W'(1);
            m_term  = 1'b1;
        end
        else if (code_unit[15:7] == 9'h000)
        begin
            m_bytes[0] = code_unit[7:0];
            m_count    = IDX_W'(1);
        end
        else if (code_unit[15:11] == 5'h00)
        begin
            m_bytes[0] = LEAD2 | {3'b000, code_unit[10:6]};
            m_bytes[1] = CONT | {2'b00, code_unit[5:0]};
            m_count    = IDX_W'(2);
        end
        else if (is_high)
        begin
            m_count = '0;
        end
        else
        begin
            m_bytes[0] = LEAD3 | {4'h0, code_unit[15:12]};
            m_bytes[1] = CONT | {2'b00, code_unit[11:6]};
            m_bytes[2] = CONT | {2'b00, code_unit[5:0]};
            m_count    = IDX_W'(3);
        end
    end

    always_comb
    begin
        run = '0;
        priority if (held_valid_reg && is_low)
        begin
            run.bytes[0] = LEAD4 | {5'h00, plane[10:8]};
            run.bytes[1] = CONT | {2'b00, plane[7:2]};
            run.bytes[2] = CONT | {2'b00, plane[1:0], code_unit[9:6]};
            run.bytes[3] = CONT | {2'b00, code_unit[5:0]};
            run.count    = IDX_W'(4);
        end
        else if (held_valid_reg)
        begin
            // Flush the lone high surrogate as three bytes, then the new unit.
            run.bytes[0] = LEAD3 | 8'h0D;
            run.bytes[1] = CONT | {2'b10, held_bits_reg[9:6]};
            run.bytes[2] = CONT | {2'b00, held_bits_reg[5:0]};
            run.bytes[3] = m_bytes[0];
            run.bytes[4] = m_bytes[1];
            run.bytes[5] = m_bytes[2];
            run.count    = IDX_W'(3) + m_count;
            run.term     = m_term;
        end
        else
        begin
            run.bytes[0] = m_bytes[0];
            run.bytes[1] = m_bytes[1];
            run.bytes[2] = m_bytes[2];
            run.count    = m_count;
            run.term     = m_term;
        end
    end

    assign push = accept && (run.count != '0);

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_bits_next  = held_bits_reg;
        if (accept)
        begin
            held_valid_next = is_high;
            held_bits_next  = code_unit[9:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_bits_reg  <= '0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            held_bits_reg  <= held_bits_next;
        end
    end

endmodule

FILE: rtl/u16u8_queue.sv
// Short queue of byte runs between the front end and the byte sender.
// Depends on u16u8_pkg for the run type and depth.
module u16u8_queue
    import u16u8_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  run_t      push_run,
    input  logic      pop,
    output run_t      head,
    output q_status_t status
);

    run_t            mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_next;
    logic [Q_CW-1:0] fill_reg;
    logic [Q_CW-1:0] fill_next;
    logic            do_push;
    logic            do_pop;

    assign status.not_empty = (fill_reg != '0);
    assign status.full      = (fill_reg == Q_CW'(Q_DEPTH));
    assign do_push          = push && !status.full;
    assign do_pop           = pop && status.not_empty;
    assign head             = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + Q_AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + Q_AW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + Q_CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - Q_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

FILE: rtl/u16u8_back.sv
// Byte sender: walks the run at the queue head and drives one byte a cycle
// into the output register unless the queue is empty or the output stalls. Depends on u16u8_pkg.
module u16u8_back
    import u16u8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  run_t       head,
    input  q_status_t  q_status,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       is_terminator,
    output logic       last_of_run
);

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             valid_reg;
    logic             valid_next;
    logic [7:0]       byte_reg;
    logic [7:0]       byte_next;
    logic             term_reg;
    logic             term_next;
    logic             last_reg;
    logic             last_next;
    logic             advance;
    logic             at_last;

    assign advance = q_status.not_empty && (!valid_reg || out_ready);
    assign at_last = (idx_reg == head.count - IDX_W'(1));
    assign pop     = advance && at_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        term_next  = term_reg;
        last_next  = last_reg;
        if (advance)
        begin
            valid_next = 1'b1;
            byte_next  = head.bytes[idx_reg];
            term_next  = at_last && head.term;
            last_next  = at_last;
            idx_next   = at_last ? '0 : idx_reg + IDX_W'(1);
        end
        else if (out_ready)
        begin
            // Drop the word once taken when nothing follows.
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        term_reg <= term_next;
        last_reg <= last_next;
    end

    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign is_terminator = term_reg;
    assign last_of_run   = last_reg;

endmodule

FILE: rtl/utf16_to_utf8_encoder_top.sv
// UTF-16 to UTF-8 encoder, top level.
// Input channel: in_valid / in_ready with one 16-bit code_unit per word.
// Output channel: out_valid / out_ready with out_byte, is_terminator and
// last_of_run; one UTF-8 byte per word.
// A unit gives one to three bytes; a high surrogate is held and gives
// nothing until the next unit, which then gives four bytes for a valid
// pair or up to six when the held surrogate is flushed alone. A zero
// unit flushes any held surrogate and then sends a zero byte with
// is_terminator set.
// The first byte of a word passes through the run queue and then the
// output register. The output register sends one byte a cycle while
// the queue holds a run and the receiver is not stalling.
// in_ready stays high while the two-entry run queue has room, so input
// is taken while earlier runs are still being sent.
// Reset clears the held surrogate, empties the queue and the output.
// When the receiver stalls the output byte holds, the queue fills and
// in_ready falls once both entries are taken.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back.
module utf16_to_utf8_encoder_top
    import u16u8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] code_unit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        is_terminator,
    output logic        last_of_run
);

    q_status_t q_status;
    run_t      push_run;
    run_t      head;
    logic      push;
    logic      pop;

    u16u8_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .code_unit (code_unit),
        .q_status  (q_status),
        .push      (push),
        .run       (push_run)
    );

    u16u8_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    u16u8_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_status      (q_status),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .is_terminator (is_terminator),
        .last_of_run   (last_of_run)
    );

`ifndef NO_ASSERTIONS
    a_term_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_terminator) |-> last_of_run)
        else $error("terminator byte not last of its run");

    a_term_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_terminator) |-> (out_byte == 8'h00))
        else $error("terminator byte not zero");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("run pushed into a full queue");

    a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (q_status.not_empty && head.count != '0))
        else $error("pop from empty queue or empty run");
`endif

endmodule
